FILE: rtl/core/lhmm_pkg.sv
`timescale 1ns / 1ps
// lhmm_pkg: shared types and constants of the luma histogram block.
// No dependencies; used by lhmm_ctrl, lhmm_datapath and luma_histogram_min_max.
package lhmm_pkg;

	// Histogram geometry
	localparam int BIN_COUNT   = 256;
	localparam int LEVEL_W     = $clog2(BIN_COUNT);
	localparam int COUNT_WIDTH = 24;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Luma weights over 1000
	localparam int SUM_W = 18;
	localparam logic [SUM_W-1:0] WEIGHT_R = SUM_W'(299);
	localparam logic [SUM_W-1:0] WEIGHT_G = SUM_W'(587);
	localparam logic [SUM_W-1:0] WEIGHT_B = SUM_W'(114);

	// Divide by 1000: ceil(2^28 / 1000), exact for every sum below 2^18
	localparam int DIV_SHIFT = 28;
	localparam int RECIP_W   = 19;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(268436);
	localparam int PROD_W    = SUM_W + RECIP_W;

	// Result levels of an empty histogram
	localparam logic [LEVEL_W-1:0] LEVEL_LOW  = '0;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH = '1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       first_of_frame;
		logic       last_of_frame;
	} pixel_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
		logic               all_empty;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic divide;
		logic read;
		logic write;
		logic scan_init;
		logic scan_step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
	} status_t;

endpackage

FILE: rtl/core/lhmm_ctrl.sv
`timescale 1ns / 1ps
// lhmm_ctrl: sequencer for one pixel beat and the end-of-frame occupancy scan.
// Depends on lhmm_pkg (cmd_t, status_t).
module lhmm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_of_frame,
	input  lhmm_pkg::status_t status,
	output logic              busy,
	output lhmm_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       last_q;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.divide = 1'b1;
				state_nxt  = ST_READ;
			end
			ST_READ: begin
				cmd.read  = 1'b1;
				state_nxt = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				if (last_q) begin
					cmd.scan_init = 1'b1;
					state_nxt     = ST_SCAN;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				last_q <= last_of_frame;
			end
		end
	end

	// Checks
	a_finish_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (state_q == ST_SCAN) && status.scan_last)
		else $error("finish outside the last scan step");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && (state_q == ST_DIV))
		else $error("accepted beat did not start processing");

	a_scan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && !status.scan_last |=> (state_q == ST_SCAN))
		else $error("scan left early");

endmodule

FILE: rtl/core/lhmm_datapath.sv
`timescale 1ns / 1ps
// lhmm_datapath: luma arithmetic, histogram memory with occupancy bits, min/max scan.
// Depends on lhmm_pkg (pixel_t, result_t, cmd_t, status_t and constants).
module lhmm_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lhmm_pkg::pixel_t  pixel,
	input  lhmm_pkg::cmd_t    cmd,
	output lhmm_pkg::status_t status,
	output lhmm_pkg::result_t result,
	output logic              done
);

	logic [lhmm_pkg::SUM_W-1:0]       sum_s1;
	logic [lhmm_pkg::PROD_W-1:0]      prod;
	logic [lhmm_pkg::LEVEL_W-1:0]     level_s2;
	logic [lhmm_pkg::COUNT_WIDTH-1:0] cnt_s3;
	logic                             hit_s3;
	logic [lhmm_pkg::COUNT_WIDTH-1:0] cnt_old;
	logic [lhmm_pkg::COUNT_WIDTH-1:0] cnt_new;

	logic [lhmm_pkg::COUNT_WIDTH-1:0] mem [lhmm_pkg::BIN_COUNT];
	logic [lhmm_pkg::BIN_COUNT-1:0]   valid_q;

	logic [lhmm_pkg::LEVEL_W-1:0]     idx_q;
	logic [lhmm_pkg::LEVEL_W-1:0]     lo_q;
	logic [lhmm_pkg::LEVEL_W-1:0]     hi_q;
	logic                             any_q;
	logic                             occ;
	logic [lhmm_pkg::LEVEL_W-1:0]     lo_nxt;
	logic [lhmm_pkg::LEVEL_W-1:0]     hi_nxt;
	logic                             any_nxt;
	lhmm_pkg::result_t                result_q;
	logic                             done_q;

	// Weighted sum, constant multiplies only
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sum_s1 <= lhmm_pkg::WEIGHT_R * lhmm_pkg::SUM_W'(pixel.red)
			        + lhmm_pkg::WEIGHT_G * lhmm_pkg::SUM_W'(pixel.green)
			        + lhmm_pkg::WEIGHT_B * lhmm_pkg::SUM_W'(pixel.blue);
		end
	end

	// Divide by 1000 through the reciprocal
	assign prod = lhmm_pkg::PROD_W'(sum_s1) * lhmm_pkg::PROD_W'(lhmm_pkg::DIV_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.divide) begin
			level_s2 <= lhmm_pkg::LEVEL_W'(prod >> lhmm_pkg::DIV_SHIFT);
		end
	end

	// Histogram memory: registered read, write back of the saturated count
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			cnt_s3 <= mem[level_s2];
		end
		if (cmd.write) begin
			mem[level_s2] <= cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			hit_s3 <= valid_q[level_s2];
		end
	end

	assign cnt_old = hit_s3 ? cnt_s3 : '0;
	assign cnt_new = (cnt_old == lhmm_pkg::COUNT_MAX) ? cnt_old
	               : cnt_old + lhmm_pkg::COUNT_WIDTH'(1);

	// Occupancy bits; an entry without one reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.capture && pixel.first_of_frame) begin
				valid_q <= '0;
			end else if (cmd.write) begin
				valid_q[level_s2] <= 1'b1;
			end
		end
	end

	// Scan of occupancy bits, one bin per cycle
	assign occ     = valid_q[idx_q];
	assign lo_nxt  = (occ && !any_q) ? idx_q : lo_q;
	assign hi_nxt  = occ ? idx_q : hi_q;
	assign any_nxt = any_q | occ;

	assign status.scan_last = (idx_q == lhmm_pkg::LEVEL_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			lo_q  <= lhmm_pkg::LEVEL_HIGH;
			hi_q  <= lhmm_pkg::LEVEL_LOW;
			any_q <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				idx_q <= '0;
				lo_q  <= lhmm_pkg::LEVEL_HIGH;
				hi_q  <= lhmm_pkg::LEVEL_LOW;
				any_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + lhmm_pkg::LEVEL_W'(1);
				lo_q  <= lo_nxt;
				hi_q  <= hi_nxt;
				any_q <= any_nxt;
			end
		end
	end

	// Result register and one-cycle strobe
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.min_level <= lo_nxt;
			result_q.max_level <= hi_nxt;
			result_q.all_empty <= !any_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	// Checks
	a_write_marks_bin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> valid_q[level_s2])
		else $error("written bin not marked occupied");

	a_min_not_above_max: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !result_q.all_empty |-> (result_q.min_level <= result_q.max_level))
		else $error("min level above max level");

	a_empty_levels: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.all_empty |->
			(result_q.min_level == lhmm_pkg::LEVEL_HIGH) &&
			(result_q.max_level == lhmm_pkg::LEVEL_LOW))
		else $error("empty result with wrong levels");

endmodule

FILE: rtl/core/luma_histogram_min_max.sv
`timescale 1ns / 1ps
// Luma histogram with lowest and highest occupied gray level.
// Depends on lhmm_pkg, lhmm_ctrl and lhmm_datapath.
//
// A pixel beat is taken when start is high and busy is low. Each pixel is turned into
// a gray level (299*R + 587*G + 114*B) div 1000 and its 24-bit bin counter is
// incremented, saturating at its maximum. A pixel marked first_of_frame clears the
// histogram before it is counted. Each pixel passes through capture and weighted sum,
// reciprocal multiply, histogram read and write back in turn, and no new beat is taken
// before its write back, owing to the read-modify-write on the single histogram memory.
// A pixel marked last_of_frame adds a scan of the 256 bin occupancy bits, one bin per
// cycle; the result appears on result with done high for exactly one cycle, rising as
// busy falls. The receiver cannot stall: the result must be taken in that cycle. Reset
// leaves the histogram empty at once, with no clearing pass.
module luma_histogram_min_max (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lhmm_pkg::pixel_t  pixel,
	output lhmm_pkg::result_t result,
	output logic              done
);

	lhmm_pkg::cmd_t    cmd;
	lhmm_pkg::status_t status;

	lhmm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_of_frame (pixel.last_of_frame),
		.status        (status),
		.busy          (busy),
		.cmd           (cmd)
	);

	lhmm_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule
